/* hw/rtl/rks_pkg.sv */
// Shared types and constants of the random key sort shuffle unit.
`timescale 1ns / 1ps

package rks_pkg;

    localparam int VAL_W      = 32;   // element value width
    localparam int KEY_W      = 32;   // random word / sort key width
    localparam int POS_W      = 10;   // position field width
    localparam int IN_TDATA_W = 64;   // value + random word
    localparam int OUT_TDATA_W = 48;  // value + position, padded to bytes
    localparam int OUT_PAD_W  = OUT_TDATA_W - VAL_W - POS_W;

    // Opcodes carried in s_axis_tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // One memory entry: key beside its value
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_entry;

endpackage

/* hw/rtl/random_key_sort_shuffle_unit.sv */
// Top level: load, key forming, odd-even merge network and readback of the shuffle.
`timescale 1ns / 1ps

// Shuffle by random keys.
// Input stream (s_axis): tuser = opcode (load / read), tdata = value and random
// word, tlast ends a loaded set. Each load writes one entry.
// The load carrying tlast starts two passes over the stored set of n items:
//   - key forming: each random word becomes its truncated signed remainder
//     by n, computed by the bit-serial remainder unit in 32 steps;
//   - sorting: Batcher odd-even merge network, descending keys, run as
//     compare/exchange over the single entry memory; a swap writes the low
//     side, then the high side (one write port).
// A set of one item skips both passes. s_axis_tready is low while they run.
// A read request passes the memory read, then the output register, and
// returns value, position and tlast on the final item; reads before the set
// is sorted are dropped. Reads wrap to position 0 after the last item.
// Output stream (m_axis) has one output register; while it is held by a
// stalled receiver, loads are still taken and a read waits for the slot.
// Reset (synchronous, active low) empties the set; memory content is kept
// but never read before being rewritten. Loads beyond MAX_ITEMS are dropped.
module random_key_sort_shuffle_unit #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rks_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // value, random_word
    input  logic                                s_axis_tuser,  // op
    input  logic                                s_axis_tlast,  // last
    // master side
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [rks_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // value_out, position
    output logic                                m_axis_tlast   // final_res
);

    localparam int IW    = $clog2(MAX_ITEMS);      // entry address width
    localparam int CW    = $clog2(MAX_ITEMS + 1);  // item count width
    localparam int PW    = IW + 1;                 // network strides / scan index
    localparam int KW    = rks_pkg::KEY_W;
    localparam int VW    = rks_pkg::VAL_W;
    localparam int POS_W = rks_pkg::POS_W;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_RD     = 10'b0000000010,  // read data back, into output register
        S_KF_RD  = 10'b0000000100,  // key forming: read entry
        S_KF_LD  = 10'b0000001000,  // key forming: start remainder
        S_KF_DIV = 10'b0000010000,  // key forming: wait, write key back
        S_SETUP  = 10'b0000100000,  // find power of two >= n
        S_SCAN   = 10'b0001000000,  // walk comparators of one pass
        S_CMP    = 10'b0010000000,  // compare pair, write low side
        S_SWAP   = 10'b0100000000,  // write high side
        S_DONE   = 10'b1000000000
    } t_state;

    // entry memory
    rks_pkg::t_entry mem [MAX_ITEMS];
    rks_pkg::t_entry r_rd_a, r_rd_b;
    logic            w_we, w_re_a, w_re_b;
    logic [IW-1:0]   w_wa, w_ra_a, w_ra_b;
    rks_pkg::t_entry w_wd;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        if (w_re_a) begin
            r_rd_a <= mem[w_ra_a];
        end
        if (w_re_b) begin
            r_rd_b <= mem[w_ra_b];
        end
    end

    // control state
    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [IW-1:0]  r_rp, n_rp;
    logic           r_sorted, n_sorted;
    logic [PW-1:0]  r_i, n_i;
    logic [PW-1:0]  r_d, n_d;
    logic [PW-1:0]  r_p, n_p;
    logic [PW-1:0]  r_q, n_q;
    logic [PW-1:0]  r_top, n_top;
    logic           r_rsel, n_rsel;    // r of the network: 0 or p
    logic           r_neg, n_neg;
    // output register
    logic           r_ov, n_ov;
    logic [VW-1:0]  r_o_val, n_o_val;
    logic [POS_W-1:0] r_o_pos, n_o_pos;
    logic           r_o_last, n_o_last;

    // remainder unit
    logic           w_div_start, w_div_done;
    logic [KW-1:0]  w_div_mag;
    logic [CW-1:0]  w_div_rem;

    rks_rem_div #(
        .DIV_W (CW)
    ) u_rem_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_mag),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    logic           w_s_acc;
    logic [VW-1:0]  w_in_val;
    logic [KW-1:0]  w_in_rw;
    logic [CW-1:0]  w_c_eff;
    logic [PW:0]    w_j;
    logic           w_sel;
    logic [PW-1:0]  w_qp;
    logic [PW-1:0]  w_p_nx;
    logic [KW-1:0]  w_rem_x;
    logic [CW-1:0]  w_rp_nx;
    logic           w_out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_s_acc    = s_axis_tvalid && s_axis_tready;
    assign w_in_val   = s_axis_tdata[VW-1:0];
    assign w_in_rw    = s_axis_tdata[VW+KW-1:VW];
    assign w_c_eff    = r_sorted ? '0 : r_count;
    assign w_j        = {1'b0, r_i} + {1'b0, r_d};
    assign w_sel      = |(r_i & r_p);
    assign w_qp       = r_q - r_p;
    assign w_p_nx     = r_p >> 1;
    assign w_rem_x    = KW'(w_div_rem);
    assign w_rp_nx    = CW'(r_rp) + 1'b1;
    assign w_out_free = !r_ov || m_axis_tready;
    assign w_div_mag  = r_rd_a.key[KW-1] ? KW'(-r_rd_a.key) : KW'(r_rd_a.key);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_rp     = r_rp;
        n_sorted = r_sorted;
        n_i      = r_i;
        n_d      = r_d;
        n_p      = r_p;
        n_q      = r_q;
        n_top    = r_top;
        n_rsel   = r_rsel;
        n_neg    = r_neg;
        n_ov     = r_ov && !m_axis_tready;
        n_o_val  = r_o_val;
        n_o_pos  = r_o_pos;
        n_o_last = r_o_last;
        w_we     = 1'b0;
        w_wa     = r_i[IW-1:0];
        w_wd     = r_rd_b;
        w_re_a   = 1'b0;
        w_ra_a   = r_i[IW-1:0];
        w_re_b   = 1'b0;
        w_ra_b   = w_j[IW-1:0];
        w_div_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_s_acc && s_axis_tuser == rks_pkg::OP_LOAD) begin
                    // a load after a sorted set opens a new one
                    n_sorted = 1'b0;
                    n_count  = w_c_eff;
                    if (r_sorted) begin
                        n_rp = '0;
                    end
                    if (w_c_eff < CW'(MAX_ITEMS)) begin
                        w_we      = 1'b1;
                        w_wa      = w_c_eff[IW-1:0];
                        w_wd.key  = w_in_rw;
                        w_wd.value = w_in_val;
                        n_count   = w_c_eff + 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_rp = '0;
                        n_i  = '0;
                        if (n_count < CW'(2)) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_KF_RD;
                        end
                    end
                end else if (w_s_acc && r_sorted && r_count != '0) begin
                    if (CW'(r_rp) >= r_count) begin
                        n_rp = '0;
                    end
                    w_re_a  = 1'b1;
                    w_ra_a  = (CW'(r_rp) >= r_count) ? '0 : r_rp;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (w_out_free) begin
                    n_ov     = 1'b1;
                    n_o_val  = r_rd_a.value;
                    n_o_pos  = POS_W'(r_rp);
                    n_o_last = (w_rp_nx == r_count);
                    n_rp     = (w_rp_nx >= r_count) ? '0 : IW'(w_rp_nx);
                    n_state  = S_IDLE;
                end
            end
            S_KF_RD: begin
                w_re_a  = 1'b1;
                n_state = S_KF_LD;
            end
            S_KF_LD: begin
                n_neg       = r_rd_a.key[KW-1];
                w_div_start = 1'b1;
                n_state     = S_KF_DIV;
            end
            S_KF_DIV: begin
                if (w_div_done) begin
                    w_we       = 1'b1;
                    w_wd.key   = r_neg ? -w_rem_x : w_rem_x;
                    w_wd.value = r_rd_a.value;
                    if ((r_i + 1'b1) == PW'(r_count)) begin
                        n_top   = PW'(1);
                        n_state = S_SETUP;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_KF_RD;
                    end
                end
            end
            S_SETUP: begin
                if (r_top < PW'(r_count)) begin
                    n_top = r_top << 1;
                end else begin
                    n_p     = r_top >> 1;
                    n_q     = r_top >> 1;
                    n_d     = r_top >> 1;
                    n_rsel  = 1'b0;
                    n_i     = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_j >= (PW+1)'(r_count)) begin
                    // pass finished: next d, q, r of the network
                    n_i    = '0;
                    n_d    = w_qp;
                    n_q    = r_q >> 1;
                    n_rsel = 1'b1;
                    if (w_qp == '0) begin
                        n_p    = w_p_nx;
                        n_q    = r_top >> 1;
                        n_d    = w_p_nx;
                        n_rsel = 1'b0;
                        if (w_p_nx == '0) begin
                            n_state = S_DONE;
                        end
                    end
                end else if (w_sel == r_rsel) begin
                    w_re_a  = 1'b1;
                    w_re_b  = 1'b1;
                    n_state = S_CMP;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_CMP: begin
                if (r_rd_a.key < r_rd_b.key) begin
                    w_we    = 1'b1;
                    w_wd    = r_rd_b;
                    n_state = S_SWAP;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SWAP: begin
                w_we    = 1'b1;
                w_wa    = w_j[IW-1:0];
                w_wd    = r_rd_a;
                n_i     = r_i + 1'b1;
                n_state = S_SCAN;
            end
            S_DONE: begin
                n_sorted = 1'b1;
                n_rp     = '0;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rp     <= '0;
            r_sorted <= 1'b0;
            r_i      <= '0;
            r_d      <= '0;
            r_p      <= '0;
            r_q      <= '0;
            r_top    <= '0;
            r_rsel   <= 1'b0;
            r_neg    <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rp     <= n_rp;
            r_sorted <= n_sorted;
            r_i      <= n_i;
            r_d      <= n_d;
            r_p      <= n_p;
            r_q      <= n_q;
            r_top    <= n_top;
            r_rsel   <= n_rsel;
            r_neg    <= n_neg;
            r_ov     <= n_ov;
        end
        r_o_val  <= n_o_val;
        r_o_pos  <= n_o_pos;
        r_o_last <= n_o_last;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {{rks_pkg::OUT_PAD_W{1'b0}}, r_o_pos, r_o_val};
    assign m_axis_tlast  = r_o_last;

endmodule

/* hw/rtl/rks_rem_div.sv */
// Bit-serial unsigned remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps

module rks_rem_div #(
    parameter int DIV_W = 11
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [rks_pkg::KEY_W-1:0]      i_dividend,
    input  logic [DIV_W-1:0]               i_divisor,
    output logic                           o_done,
    output logic [DIV_W-1:0]               o_rem
);

    localparam int KW  = rks_pkg::KEY_W;
    localparam int CNW = $clog2(KW);

    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [CNW-1:0] r_cnt, n_cnt;
    logic [KW-1:0]  r_dvd, n_dvd;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W:0] w_sh;

    assign w_sh = {r_rem, r_dvd[KW-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            // restoring step: shift in next bit, subtract if it fits
            if (w_sh >= {1'b0, i_divisor}) begin
                n_rem = DIV_W'(w_sh - {1'b0, i_divisor});
            end else begin
                n_rem = w_sh[DIV_W-1:0];
            end
            n_dvd = {r_dvd[KW-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNW'(KW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
